// ----- rtl/tgarle_pkg.sv -----
`default_nettype none
package tgarle_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_PIXEL_FORMAT   = 3'd0,
    CFG_COMPRESSED     = 3'd1,
    CFG_LINE_WIDTH     = 3'd2,
    CFG_RED_POS        = 3'd3,
    CFG_GREEN_POS      = 3'd4,
    CFG_BLUE_POS       = 3'd5,
    CFG_ALPHA_POS      = 3'd6,
    CFG_SHIFT16_PACKED = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_INDEX8 = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_BGR24  = 2'd2,
    FMT_BGRA32 = 2'd3
  } pix_fmt_e;

  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic        compressed;
    logic [15:0] line_width;
    logic [1:0]  red_pos;
    logic [1:0]  green_pos;
    logic [1:0]  blue_pos;
    logic [1:0]  alpha_pos;
    logic [11:0] shift16_packed;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    pixel_format:   2'd0,
    compressed:     1'b1,
    line_width:     16'd1,
    red_pos:        2'd2,
    green_pos:      2'd1,
    blue_pos:       2'd0,
    alpha_pos:      2'd3,
    shift16_packed: 12'hA50
  };

  // one assembled pixel handed from front to back
  typedef struct packed {
    logic [31:0] raw;
    logic [7:0]  rep;
    logic        test_line;
  } job_t;

  function automatic logic [31:0] build_pixel(input logic [31:0] raw, input cfg_t c);
    logic [31:0] w;
    logic [31:0] w16;
    logic [7:0]  b;
    begin
      w = '0;
      w16 = ({27'b0, raw[14:10]} << c.shift16_packed[11:8])
          | ({27'b0, raw[9:5]}   << c.shift16_packed[7:4])
          | ({27'b0, raw[4:0]}   << c.shift16_packed[3:0]);
      for (int k = 0; k < 4; k++) begin
        // first match wins: blue over green over red over alpha
        if (c.blue_pos == 2'(k))
          b = raw[7:0];
        else if (c.green_pos == 2'(k))
          b = raw[15:8];
        else if (c.red_pos == 2'(k))
          b = raw[23:16];
        else if (c.pixel_format == FMT_BGRA32 && c.alpha_pos == 2'(k))
          b = raw[31:24];
        else
          b = 8'd0;
        w[8*k +: 8] = b;
      end
      case (pix_fmt_e'(c.pixel_format))
        FMT_INDEX8: build_pixel = {24'b0, raw[7:0]};
        FMT_RGB555: build_pixel = {16'b0, w16[15:0]};
        default:    build_pixel = w;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tgarle_front.sv -----
`default_nettype none
module tgarle_front
  import tgarle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic        expect_q, expect_d;
  logic        raw_q, raw_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] merged;
  logic        take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign merged     = bytes_q | ({24'b0, in_byte_i} << {idx_q, 3'b000});

  always_comb begin
    expect_d = expect_q;
    raw_d    = raw_q;
    left_d   = left_q;
    idx_d    = idx_q;
    bytes_d  = bytes_q;
    push_o   = 1'b0;
    job_o    = '{raw: merged, rep: 8'd1, test_line: 1'b1};
    if (take) begin
      if (cfg_i.compressed && expect_q) begin
        raw_d    = !in_byte_i[7];
        left_d   = {1'b0, in_byte_i[6:0]} + 8'd1;
        expect_d = 1'b0;
        idx_d    = '0;
        bytes_d  = '0;
      end else if (idx_q < cfg_i.pixel_format) begin
        idx_d   = idx_q + 2'd1;
        bytes_d = merged;
      end else begin
        push_o  = 1'b1;
        idx_d   = '0;
        bytes_d = '0;
        if (cfg_i.compressed) begin
          if (raw_q) begin
            job_o.test_line = (left_q <= 8'd1);
            left_d = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
            if (left_q <= 8'd1)
              expect_d = 1'b1;
          end else begin
            job_o.rep = (left_q != 8'd0) ? left_q : 8'd1;
            left_d    = '0;
            expect_d  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      raw_q    <= 1'b0;
      left_q   <= '0;
      idx_q    <= '0;
      bytes_q  <= '0;
    end else begin
      expect_q <= expect_d;
      raw_q    <= raw_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      bytes_q  <= bytes_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tgarle_queue.sv -----
`default_nettype none
module tgarle_queue
  import tgarle_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output job_t      head_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push)
      mem[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push)
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)
        cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push)
        cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ----- rtl/tgarle_back.sv -----
`default_nettype none
module tgarle_back
  import tgarle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic head_valid_i,
  input  wire job_t head_i,
  output logic      pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [31:0] pixel_o,
  output logic [7:0]  repeat_res_o,
  output logic        line_end_o
);

  logic        out_valid_q;
  logic [31:0] pixel_q;
  logic [7:0]  rep_q;
  logic        line_end_q, line_end_d;
  logic [16:0] lc_q, lc_d, lc_sum;

  assign pop_o      = head_valid_i && (!out_valid_q || out_ready_i);
  assign lc_sum     = lc_q + {9'b0, head_i.rep};
  assign line_end_d = head_i.test_line && (lc_sum >= {1'b0, cfg_i.line_width});
  assign lc_d       = line_end_d ? '0 : lc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lc_q        <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        lc_q        <= lc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q    <= build_pixel(head_i.raw, cfg_i);
      rep_q      <= head_i.rep;
      line_end_q <= line_end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_o      = pixel_q;
  assign repeat_res_o = rep_q;
  assign line_end_o   = line_end_q;

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rep_q != 8'd0) else $error("zero repeat on output");

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && line_end_d) |=> lc_q == '0)
    else $error("line count not cleared after line end");

endmodule
`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder_top.sv -----
`default_nettype none
// TGA run-length scanline decoder. Takes one stream byte per clock on the in
// channel (header or pixel byte) and returns one result per finished pixel:
// the pixel word, a repeat count of 1 to 128 and a line-end flag. Bytes go in
// at one per cycle with no gaps while the out side keeps up; the front parser
// fills a QDEPTH-entry queue and the back end drains one pixel per cycle into
// the output register while the out side accepts, so a stalled out side stops
// the in side only once that queue is full. A result passes through the queue
// and the output register after its last byte. Configuration writes are
// registered and always ready; change them only while the decoder is idle.
module tga_rle_pixel_decoder_top
  import tgarle_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              pixel_o,
  output logic [7:0]               repeat_res_o,
  output logic                     line_end_o
);

  cfg_t cfg_q;
  logic q_full, push, pop, head_valid;
  job_t job, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_FORMAT:   cfg_q.pixel_format   <= cfg_data_i[1:0];
        CFG_COMPRESSED:     cfg_q.compressed     <= cfg_data_i[0];
        CFG_LINE_WIDTH:     cfg_q.line_width     <= cfg_data_i[15:0];
        CFG_RED_POS:        cfg_q.red_pos        <= cfg_data_i[1:0];
        CFG_GREEN_POS:      cfg_q.green_pos      <= cfg_data_i[1:0];
        CFG_BLUE_POS:       cfg_q.blue_pos       <= cfg_data_i[1:0];
        CFG_ALPHA_POS:      cfg_q.alpha_pos      <= cfg_data_i[1:0];
        CFG_SHIFT16_PACKED: cfg_q.shift16_packed <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  tgarle_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tgarle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_o      (pixel_o),
    .repeat_res_o (repeat_res_o),
    .line_end_o   (line_end_o)
  );

endmodule
`default_nettype wire
